// ===== rtl/allm_pkg.sv =====
// Shared types and codes for the array linked list manager.
// Holds the transaction structs, opcode and status codes, and default sizes.
// No dependencies.
package allm_pkg;

    localparam int CAPACITY_DEF    = 64;
    localparam int HANDLE_BITS_DEF = 32;

    localparam logic [2:0] OP_ADD       = 3'd0;
    localparam logic [2:0] OP_RM_SLOT   = 3'd1;
    localparam logic [2:0] OP_RM_HANDLE = 3'd2;
    localparam logic [2:0] OP_FIRST     = 3'd3;
    localparam logic [2:0] OP_NEXT      = 3'd4;
    localparam logic [2:0] OP_CLEAR     = 3'd5;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_MISSING = 2'd2;
    localparam logic [1:0] ST_END     = 2'd3;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [31:0] handle_in;
        logic [5:0]  slot_in;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  slot_out;
        logic [31:0] handle_out;
    } rsp_t;

endpackage

// ===== rtl/array_linked_list_manager.sv =====
// Pool of CAPACITY slots kept as a doubly linked list of handles plus a free
// chain, all links held in synchronous RAMs and updated by read-modify-write
// steps of a sequencer, one transaction at a time. Remove by handle compares
// one slot per cycle. Each result waits in the output register while the
// next transaction is taken. After reset the block sweeps every slot of the
// RAMs before taking its first transaction. Depends on allm_pkg and
// allm_ram.
module array_linked_list_manager
    import allm_pkg::*;
#(
    parameter int CAPACITY    = CAPACITY_DEF,
    parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    localparam int SLOT_W = $clog2(CAPACITY);
    localparam int LINK_W = $clog2(CAPACITY + 1);
    localparam logic [LINK_W-1:0] LNULL = LINK_W'(CAPACITY);
    localparam logic [SLOT_W-1:0] LAST  = SLOT_W'(CAPACITY - 1);

    typedef enum logic [8:0] {
        S_INIT    = 9'b000000001,
        S_IDLE    = 9'b000000010,
        S_ADD_WR  = 9'b000000100,
        S_RM_LINK = 9'b000001000,
        S_RM_FREE = 9'b000010000,
        S_SCAN    = 9'b000100000,
        S_WALK    = 9'b001000000,
        S_HDL_RD  = 9'b010000000,
        S_DONE    = 9'b100000000
    } state_t;

    state_t                 state_reg, state_next;
    logic [SLOT_W-1:0]      sweep_reg, sweep_next;
    logic                   emit_reg, emit_next;
    logic [SLOT_W-1:0]      idx_reg, idx_next;
    logic [SLOT_W-1:0]      scan_reg, scan_next;
    logic [SLOT_W-1:0]      cmp_idx_reg, cmp_idx_next;
    logic [HANDLE_BITS-1:0] h_reg, h_next;
    logic [LINK_W-1:0]      head_reg, head_next;
    logic [LINK_W-1:0]      free_reg, free_next;
    logic [LINK_W-1:0]      cur_reg, cur_next;
    rsp_t                   res_reg, res_next;
    logic                   rsp_valid_reg, rsp_valid_next;
    rsp_t                   rsp_reg;

    logic [SLOT_W-1:0]      rd_addr;
    logic                   fwd_we, bwd_we, occ_we, hdl_we;
    logic [SLOT_W-1:0]      fwd_waddr, bwd_waddr, occ_waddr, hdl_waddr;
    logic [LINK_W-1:0]      fwd_wdata, bwd_wdata;
    logic                   occ_wdata;
    logic [HANDLE_BITS-1:0] hdl_wdata;
    logic [LINK_W-1:0]      fwd_rd, bwd_rd;
    logic                   occ_rd;
    logic [HANDLE_BITS-1:0] hdl_rd;
    logic                   out_free;

    allm_ram #(.WIDTH(LINK_W), .DEPTH(CAPACITY)) u_fwd (
        .clk(clk), .we(fwd_we), .waddr(fwd_waddr), .wdata(fwd_wdata),
        .raddr(rd_addr), .rdata(fwd_rd)
    );

    allm_ram #(.WIDTH(LINK_W), .DEPTH(CAPACITY)) u_bwd (
        .clk(clk), .we(bwd_we), .waddr(bwd_waddr), .wdata(bwd_wdata),
        .raddr(rd_addr), .rdata(bwd_rd)
    );

    allm_ram #(.WIDTH(1), .DEPTH(CAPACITY)) u_occ (
        .clk(clk), .we(occ_we), .waddr(occ_waddr), .wdata(occ_wdata),
        .raddr(rd_addr), .rdata(occ_rd)
    );

    allm_ram #(.WIDTH(HANDLE_BITS), .DEPTH(CAPACITY)) u_hdl (
        .clk(clk), .we(hdl_we), .waddr(hdl_waddr), .wdata(hdl_wdata),
        .raddr(rd_addr), .rdata(hdl_rd)
    );

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign out_free  = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        state_next   = state_reg;
        sweep_next   = sweep_reg;
        emit_next    = emit_reg;
        idx_next     = idx_reg;
        scan_next    = scan_reg;
        cmp_idx_next = cmp_idx_reg;
        h_next       = h_reg;
        head_next    = head_reg;
        free_next    = free_reg;
        cur_next     = cur_reg;
        res_next     = res_reg;
        rd_addr      = '0;
        fwd_we       = 1'b0;
        fwd_waddr    = '0;
        fwd_wdata    = '0;
        bwd_we       = 1'b0;
        bwd_waddr    = '0;
        bwd_wdata    = '0;
        occ_we       = 1'b0;
        occ_waddr    = '0;
        occ_wdata    = 1'b0;
        hdl_we       = 1'b0;
        hdl_waddr    = '0;
        hdl_wdata    = '0;

        unique case (state_reg)
            S_INIT:
            begin
                // rebuild one slot per cycle; the last slot links to null
                fwd_we    = 1'b1;
                fwd_waddr = sweep_reg;
                fwd_wdata = LINK_W'(sweep_reg) + LINK_W'(1);
                bwd_we    = 1'b1;
                bwd_waddr = sweep_reg;
                bwd_wdata = LNULL;
                occ_we    = 1'b1;
                occ_waddr = sweep_reg;
                occ_wdata = 1'b0;
                if (sweep_reg == LAST)
                begin
                    sweep_next = '0;
                    if (emit_reg)
                    begin
                        res_next   = '0;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    sweep_next = sweep_reg + SLOT_W'(1);
                end
            end

            S_IDLE:
            begin
                if (req_valid)
                begin
                    h_next   = HANDLE_BITS'(req.handle_in);
                    res_next = '0;
                    unique case (req.opcode)
                        OP_ADD:
                        begin
                            if (free_reg == LNULL)
                            begin
                                res_next.status = ST_FULL;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                idx_next  = free_reg[SLOT_W-1:0];
                                rd_addr   = free_reg[SLOT_W-1:0];
                                bwd_we    = 1'b1;
                                bwd_waddr = free_reg[SLOT_W-1:0];
                                bwd_wdata = LNULL;
                                occ_we    = 1'b1;
                                occ_waddr = free_reg[SLOT_W-1:0];
                                occ_wdata = 1'b1;
                                hdl_we    = 1'b1;
                                hdl_waddr = free_reg[SLOT_W-1:0];
                                hdl_wdata = HANDLE_BITS'(req.handle_in);
                                state_next = S_ADD_WR;
                            end
                        end
                        OP_RM_SLOT:
                        begin
                            if (int'(req.slot_in) < CAPACITY)
                            begin
                                idx_next   = SLOT_W'(req.slot_in);
                                rd_addr    = SLOT_W'(req.slot_in);
                                state_next = S_RM_LINK;
                            end
                            else
                            begin
                                res_next.status = ST_MISSING;
                                state_next      = S_DONE;
                            end
                        end
                        OP_RM_HANDLE:
                        begin
                            rd_addr      = '0;
                            cmp_idx_next = '0;
                            scan_next    = SLOT_W'(1);
                            state_next   = S_SCAN;
                        end
                        OP_FIRST:
                        begin
                            cur_next = head_reg;
                            if (head_reg != LNULL)
                            begin
                                rd_addr    = head_reg[SLOT_W-1:0];
                                state_next = S_HDL_RD;
                            end
                            else
                            begin
                                res_next.status = ST_END;
                                state_next      = S_DONE;
                            end
                        end
                        OP_NEXT:
                        begin
                            if (cur_reg != LNULL)
                            begin
                                rd_addr    = cur_reg[SLOT_W-1:0];
                                state_next = S_WALK;
                            end
                            else
                            begin
                                res_next.status = ST_END;
                                state_next      = S_DONE;
                            end
                        end
                        OP_CLEAR:
                        begin
                            head_next  = LNULL;
                            free_next  = '0;
                            cur_next   = LNULL;
                            emit_next  = 1'b1;
                            sweep_next = '0;
                            state_next = S_INIT;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_ADD_WR:
            begin
                free_next = fwd_rd;
                fwd_we    = 1'b1;
                fwd_waddr = idx_reg;
                fwd_wdata = head_reg;
                if (head_reg != LNULL)
                begin
                    bwd_we    = 1'b1;
                    bwd_waddr = head_reg[SLOT_W-1:0];
                    bwd_wdata = LINK_W'(idx_reg);
                end
                head_next         = LINK_W'(idx_reg);
                res_next.slot_out = 6'(idx_reg);
                state_next        = S_DONE;
            end

            S_RM_LINK:
            begin
                if (!occ_rd)
                begin
                    res_next.status = ST_MISSING;
                    state_next      = S_DONE;
                end
                else
                begin
                    if (LINK_W'(idx_reg) == head_reg)
                    begin
                        head_next = fwd_rd;
                    end
                    else if (bwd_rd != LNULL)
                    begin
                        fwd_we    = 1'b1;
                        fwd_waddr = bwd_rd[SLOT_W-1:0];
                        fwd_wdata = fwd_rd;
                    end
                    if (fwd_rd != LNULL)
                    begin
                        // successor gets a null back link if it becomes head, else the removed slot's back link
                        bwd_we    = 1'b1;
                        bwd_waddr = fwd_rd[SLOT_W-1:0];
                        bwd_wdata = (LINK_W'(idx_reg) == head_reg) ? LNULL : bwd_rd;
                    end
                    if (cur_reg == LINK_W'(idx_reg))
                    begin
                        cur_next = LNULL;
                    end
                    occ_we     = 1'b1;
                    occ_waddr  = idx_reg;
                    occ_wdata  = 1'b0;
                    state_next = S_RM_FREE;
                end
            end

            S_RM_FREE:
            begin
                fwd_we            = 1'b1;
                fwd_waddr         = idx_reg;
                fwd_wdata         = free_reg;
                bwd_we            = 1'b1;
                bwd_waddr         = idx_reg;
                bwd_wdata         = LNULL;
                free_next         = LINK_W'(idx_reg);
                res_next.status   = ST_OK;
                res_next.slot_out = 6'(idx_reg);
                state_next        = S_DONE;
            end

            S_SCAN:
            begin
                if (occ_rd && (hdl_rd == h_reg))
                begin
                    idx_next   = cmp_idx_reg;
                    rd_addr    = cmp_idx_reg;
                    state_next = S_RM_LINK;
                end
                else if (cmp_idx_reg == LAST)
                begin
                    res_next.status = ST_MISSING;
                    state_next      = S_DONE;
                end
                else
                begin
                    rd_addr      = scan_reg;
                    cmp_idx_next = scan_reg;
                    scan_next    = scan_reg + SLOT_W'(1);
                end
            end

            S_WALK:
            begin
                cur_next = fwd_rd;
                if (fwd_rd != LNULL)
                begin
                    rd_addr    = fwd_rd[SLOT_W-1:0];
                    state_next = S_HDL_RD;
                end
                else
                begin
                    res_next.status = ST_END;
                    state_next      = S_DONE;
                end
            end

            S_HDL_RD:
            begin
                res_next.status     = ST_OK;
                res_next.slot_out   = 6'(cur_reg[SLOT_W-1:0]);
                res_next.handle_out = 32'(hdl_rd);
                state_next          = S_DONE;
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        if (state_reg == S_DONE && out_free)
        begin
            rsp_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            sweep_reg     <= '0;
            emit_reg      <= 1'b0;
            head_reg      <= LNULL;
            free_reg      <= '0;
            cur_reg       <= LNULL;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_reg     <= sweep_next;
            emit_reg      <= emit_next;
            head_reg      <= head_next;
            free_reg      <= free_next;
            cur_reg       <= cur_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        scan_reg    <= scan_next;
        cmp_idx_reg <= cmp_idx_next;
        h_reg       <= h_next;
        res_reg     <= res_next;
        if (state_reg == S_DONE && out_free)
        begin
            rsp_reg <= res_reg;
        end
    end

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> (state_reg != S_IDLE))
        else $error("accepted transaction did not start the sequencer");

    a_lists_disjoint: assert property (@(posedge clk) disable iff (!rst_n)
        (head_reg == free_reg) |-> (head_reg == LNULL))
        else $error("list head and free head point at the same slot");

    a_done_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_free) |=> (rsp_valid && state_reg == S_IDLE))
        else $error("finished result not loaded into output register");

    a_links_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (head_reg <= LNULL) && (free_reg <= LNULL) && (cur_reg <= LNULL))
        else $error("link register beyond null");

endmodule

// ===== rtl/allm_ram.sv =====
// Simple dual port synchronous RAM: one write port, one registered read port.
// Used for the link, occupancy and handle stores. No dependencies.
module allm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
